FILE: design/mst_pkg.sv
// ----------------------------------------------------------------------------
// mst_pkg
// Shared types and constants for the membership set table.
// ----------------------------------------------------------------------------
package mst_pkg;

    // Fixed field widths of the transaction ports
    localparam int unsigned ELEM_IN_BITS = 32;
    localparam int unsigned CMD_BITS     = 2;
    localparam int unsigned COUNT_BITS   = 7;

    // Command codes
    localparam logic [CMD_BITS-1:0] CMD_ADD    = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_SEARCH = 2'd2;

    // Match tracker flags handed from the scan unit to the controller
    typedef struct packed {
        logic hit;
        logic free_found;
    } t_scan_flags;

endpackage

FILE: design/mst_ram.sv
// ----------------------------------------------------------------------------
// mst_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module mst_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                       i_wr_data,
    input  logic                                   i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                       o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: design/mst_scan.sv
// ----------------------------------------------------------------------------
// mst_scan
// Match tracker: compares each row read from the slot RAM with the key and
// keeps the first matching slot and the lowest free slot of the scan.
// ----------------------------------------------------------------------------
module mst_scan
    import mst_pkg::*;
#(
    parameter int unsigned CAPACITY     = 64,
    parameter int unsigned ELEMENT_BITS = 32
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_start,
    input  logic                                       i_chk_vld,
    input  logic [$clog2(CAPACITY)-1:0]                i_chk_addr,
    input  logic [ELEMENT_BITS:0]                      i_rd_row,
    input  logic [ELEMENT_BITS-1:0]                    i_key,
    output t_scan_flags                                o_flags,
    output logic [$clog2(CAPACITY)-1:0]                o_hit_idx,
    output logic [$clog2(CAPACITY)-1:0]                o_free_idx
);

    localparam int unsigned AW = $clog2(CAPACITY);

    logic          r_hit;
    logic          r_free;
    logic [AW-1:0] r_hit_idx;
    logic [AW-1:0] r_free_idx;
    logic          w_row_vld;
    logic          w_match;

    assign w_row_vld = i_rd_row[ELEMENT_BITS];
    assign w_match   = w_row_vld && (i_rd_row[ELEMENT_BITS-1:0] == i_key);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_start) begin
            r_hit  <= 1'b0;
            r_free <= 1'b0;
        end else if (i_chk_vld) begin
            // keep the first hit and the lowest free slot only
            if (w_match && !r_hit) begin
                r_hit     <= 1'b1;
                r_hit_idx <= i_chk_addr;
            end
            if (!w_row_vld && !r_free) begin
                r_free     <= 1'b1;
                r_free_idx <= i_chk_addr;
            end
        end
    end

    assign o_flags.hit        = r_hit;
    assign o_flags.free_found = r_free;
    assign o_hit_idx          = r_hit_idx;
    assign o_free_idx         = r_free_idx;

endmodule

FILE: design/membership_set_table_top.sv
// ----------------------------------------------------------------------------
// membership_set_table_top
// Sequence: an input transaction is accepted, the RAM scan reads every slot at
//   one slot per cycle, then an update state loads the result register.
// Issue: a new transaction is taken only once the last one is done, as the
//   single read port of the slot RAM is passed by every slot once per command,
//   with an idle state to take the next transaction; a stalled result holds the
//   update state until the result register frees up.
// Reset: synchronous, active low; count and flags clear, then a clearing pass
//   over every slot marks it free while o_ready stays low.
// ----------------------------------------------------------------------------
module membership_set_table_top
    import mst_pkg::*;
#(
    parameter int unsigned CAPACITY     = 64,
    parameter int unsigned ELEMENT_BITS = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input transaction
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [CMD_BITS-1:0]            i_command,
    input  logic signed [ELEM_IN_BITS-1:0] i_element,
    // result transaction
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic                           o_success,
    output logic                           o_capacity_refused,
    output logic [COUNT_BITS-1:0]          o_element_count,
    output logic                           o_set_empty
);

    localparam int unsigned AW    = $clog2(CAPACITY);
    localparam int unsigned SW    = AW + 1;                  // scan counter, reaches CAPACITY
    localparam int unsigned CW    = $clog2(CAPACITY + 1);    // held count
    localparam int unsigned ROW_W = ELEMENT_BITS + 1;        // {valid, value}
    localparam int unsigned EXT_W = ELEMENT_BITS + ELEM_IN_BITS;

    // state codes
    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_SCAN  = 2'd2;
    localparam logic [1:0] S_UPD   = 2'd3;

    logic [1:0]              r_state, n_state;
    logic [SW-1:0]           r_rd_cnt, n_rd_cnt;
    logic                    r_chk_vld;
    logic [AW-1:0]           r_chk_addr;
    logic [CMD_BITS-1:0]     r_cmd;
    logic [ELEMENT_BITS-1:0] r_key;
    logic [CW-1:0]           r_count, n_count;

    // output register
    logic                    r_out_vld;
    logic                    r_out_success;
    logic                    r_out_refused;
    logic [COUNT_BITS-1:0]   r_out_cnt;
    logic                    r_out_empty;

    logic                    w_accept;
    logic                    w_out_free;
    logic                    w_out_load;
    logic [EXT_W-1:0]        w_key_ext;
    logic                    w_rd_en;
    logic [AW-1:0]           w_rd_addr;
    logic [ROW_W-1:0]        w_rd_row;
    logic                    w_wr_en;
    logic [AW-1:0]           w_wr_addr;
    logic [ROW_W-1:0]        w_wr_data;
    logic                    w_scan_last;
    logic                    w_add_ok;
    logic                    w_add_refused;
    logic                    w_rem_ok;
    logic                    w_success;
    logic [CW+COUNT_BITS-1:0] w_cnt_ext;

    t_scan_flags             w_flags;
    logic [AW-1:0]           w_hit_idx;
    logic [AW-1:0]           w_free_idx;

    // Only the low ELEMENT_BITS of the zero-extended element are stored and compared
    assign w_key_ext = {{ELEMENT_BITS{1'b0}}, i_element};

    assign o_ready    = (r_state == S_IDLE);
    assign w_accept   = i_valid && o_ready;
    assign w_out_free = !r_out_vld || i_ready;

    // Scan issues one RAM read per cycle; the row comes back in the cycle after
    assign w_rd_en     = (r_state == S_SCAN) && (r_rd_cnt != SW'(CAPACITY));
    assign w_rd_addr   = r_rd_cnt[AW-1:0];
    assign w_scan_last = r_chk_vld && (r_chk_addr == AW'(CAPACITY - 1));

    // Decide the command from the tracker once every slot has been seen
    assign w_add_ok      = (r_cmd == CMD_ADD) && !w_flags.hit && w_flags.free_found
                           && (r_count < CW'(CAPACITY));
    assign w_add_refused = (r_cmd == CMD_ADD) && !w_flags.hit && !w_add_ok;
    assign w_rem_ok      = (r_cmd == CMD_REMOVE) && w_flags.hit;
    assign w_success     = w_add_ok || w_rem_ok || ((r_cmd == CMD_SEARCH) && w_flags.hit);
    assign w_out_load    = (r_state == S_UPD) && w_out_free;

    // RAM write: clearing pass, or the single slot update of an add or remove.
    // Reads and writes never overlap, so no forwarding is needed.
    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = r_rd_cnt[AW-1:0];
        w_wr_data = '0;
        if (r_state == S_CLEAR) begin
            w_wr_en = 1'b1;
        end else if (w_out_load && w_add_ok) begin
            w_wr_en   = 1'b1;
            w_wr_addr = w_free_idx;
            w_wr_data = {1'b1, r_key};
        end else if (w_out_load && w_rem_ok) begin
            w_wr_en   = 1'b1;
            w_wr_addr = w_hit_idx;
            w_wr_data = {1'b0, r_key};
        end
    end

    // Held count after this command
    always_comb begin
        n_count = r_count;
        if (w_add_ok) begin
            n_count = r_count + CW'(1);
        end else if (w_rem_ok && (r_count != '0)) begin
            n_count = r_count - CW'(1);
        end
    end

    assign w_cnt_ext = {{COUNT_BITS{1'b0}}, n_count};

    // Sequencer
    always_comb begin
        n_state  = r_state;
        n_rd_cnt = r_rd_cnt;
        unique case (r_state)
            S_CLEAR: begin
                n_rd_cnt = r_rd_cnt + SW'(1);
                if (r_rd_cnt == SW'(CAPACITY - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                n_rd_cnt = '0;
                if (w_accept) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_rd_en) begin
                    n_rd_cnt = r_rd_cnt + SW'(1);
                end
                if (w_scan_last) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_rd_cnt  <= '0;
            r_chk_vld <= 1'b0;
            r_count   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd_cnt  <= n_rd_cnt;
            r_chk_vld <= w_rd_en;
            if (w_out_load) begin
                r_count   <= n_count;
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Payload registers, no reset
    always_ff @(posedge i_clk) begin
        r_chk_addr <= w_rd_addr;
        if (w_accept) begin
            r_cmd <= i_command;
            r_key <= w_key_ext[ELEMENT_BITS-1:0];
        end
        if (w_out_load) begin
            r_out_success <= w_success;
            r_out_refused <= w_add_refused;
            r_out_cnt     <= w_cnt_ext[COUNT_BITS-1:0];
            r_out_empty   <= (n_count == '0);
        end
    end

    assign o_valid            = r_out_vld;
    assign o_success          = r_out_success;
    assign o_capacity_refused = r_out_refused;
    assign o_element_count    = r_out_cnt;
    assign o_set_empty        = r_out_empty;

    // Slot store: one row per slot holding {valid, value}
    mst_ram #(
        .WIDTH (ROW_W),
        .DEPTH (CAPACITY)
    ) u_slot_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_row)
    );

    mst_scan #(
        .CAPACITY     (CAPACITY),
        .ELEMENT_BITS (ELEMENT_BITS)
    ) u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_accept),
        .i_chk_vld  (r_chk_vld),
        .i_chk_addr (r_chk_addr),
        .i_rd_row   (w_rd_row),
        .i_key      (r_key),
        .o_flags    (w_flags),
        .o_hit_idx  (w_hit_idx),
        .o_free_idx (w_free_idx)
    );

    // Held count never passes the number of slots
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("held count exceeds capacity");

    // A refused add never reports success
    a_refuse_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_capacity_refused) |-> !o_success)
        else $error("refused add flagged as success");

    // A successful add grows the count by exactly one
    a_add_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_load && w_add_ok) |=> (r_count == $past(r_count) + CW'(1)))
        else $error("add did not advance count");

    // No RAM read is issued while a slot update is written
    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_en |-> !w_rd_en)
        else $error("read and write overlap in slot RAM");

endmodule
